>>> hdl/mtf_pkg.sv
// shared types and constants for the max tracking fifo
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int unsigned CAP_W  = 11;
  localparam int unsigned DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic signed [DATA_W-1:0] MAX_FLOOR = -32'sd2147483647;
  localparam logic signed [DATA_W-1:0] MOST_NEG  = 32'sh8000_0000;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_MAX = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic deq_finish;
    logic scan;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic deq_start;
    logic rescan_needed;
    logic scan_done;
  } dp_stat_t;

endpackage

>>> hdl/mtf_ctrl.sv
// controller state machine for the max tracking fifo
`timescale 1ns / 1ps

module mtf_ctrl import mtf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        cmd_o.accept = in_valid_i && stat_i.out_free;
        if (cmd_o.accept && stat_i.deq_start) begin
          state_d = S_DEQ;
        end
      end
      S_DEQ: begin
        cmd_o.deq_finish = 1'b1;
        state_d = stat_i.rescan_needed ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/mtf_datapath.sv
// ring store, max tracking, rescan and output register
`timescale 1ns / 1ps

module mtf_datapath import mtf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic [1:0]               command_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_EXT = CMP_W'(QUEUE_DEPTH);

  logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;

  logic [CAP_W-1:0]         capacity_q;
  logic [IDX_W-1:0]         head_q, head_d, tail_q, tail_d, scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]         count_q, count_d, copies_q, copies_d;
  logic [CNT_W-1:0]         left_q, left_d, copies_dec;
  logic signed [DATA_W-1:0] max_q, max_d, enq_val;
  logic                     rd_vld_q, rd_vld_d;

  logic                     out_valid_q, ld_out;
  logic [1:0]               res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [1:0]               status_q;
  logic signed [DATA_W-1:0] data_q;

  logic [CMP_W-1:0]         cap_ext, cap_eff;
  logic                     empty, full;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  assign cap_ext = CMP_W'(capacity_q);
  assign cap_eff = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;
  assign empty   = (count_q == '0);
  assign full    = (CMP_W'(count_q) >= cap_eff);
  assign enq_val = (value_i == MOST_NEG) ? MAX_FLOOR : value_i;

  // copy count after the word in rd_data_q leaves the head
  assign copies_dec = ((rd_data_q == max_q) && (copies_q != '0))
                      ? copies_q - CNT_W'(1) : copies_q;

  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign stat_o.deq_start     = (command_i == CMD_DEQ) && !empty;
  assign stat_o.rescan_needed = (copies_dec == '0);
  assign stat_o.scan_done     = (left_q == '0) && !rd_vld_q;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    max_d      = max_q;
    copies_d   = copies_q;
    scan_ptr_d = scan_ptr_q;
    left_d     = left_q;
    rd_vld_d   = 1'b0;
    rd_addr    = head_q;
    wr_en      = 1'b0;
    ld_out     = 1'b0;
    res_status = ST_OK;
    res_data   = '0;

    if (cmd_i.accept) begin
      case (command_i)
        CMD_ENQ: begin
          ld_out = 1'b1;
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            tail_d  = wrap_next(tail_q);
            count_d = count_q + CNT_W'(1);
            if (enq_val > max_q) begin
              max_d    = enq_val;
              copies_d = CNT_W'(1);
            end else if (enq_val == max_q) begin
              copies_d = copies_q + CNT_W'(1);
            end
          end
        end
        CMD_DEQ: begin
          // non-empty dequeue finishes once the head word is read
          if (empty) begin
            ld_out     = 1'b1;
            res_status = ST_EMPTY;
          end
        end
        CMD_MAX: begin
          ld_out = 1'b1;
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_data = max_q;
          end
        end
        default: begin
          ld_out = 1'b1;
        end
      endcase
    end

    if (cmd_i.deq_finish) begin
      ld_out   = 1'b1;
      res_data = rd_data_q;
      head_d   = wrap_next(head_q);
      count_d  = count_q - CNT_W'(1);
      copies_d = copies_dec;
      if (copies_dec == '0) begin
        max_d      = MAX_FLOOR;
        scan_ptr_d = wrap_next(head_q);
        left_d     = count_q - CNT_W'(1);
      end
    end

    if (cmd_i.scan) begin
      rd_addr = scan_ptr_q;
      if (left_q != '0) begin
        rd_vld_d   = 1'b1;
        scan_ptr_d = wrap_next(scan_ptr_q);
        left_d     = left_q - CNT_W'(1);
      end
      if (rd_vld_q) begin
        if (rd_data_q > max_q) begin
          max_d    = rd_data_q;
          copies_d = CNT_W'(1);
        end else if (rd_data_q == max_q) begin
          copies_d = copies_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= enq_val;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      max_q       <= MAX_FLOOR;
      copies_q    <= '0;
      scan_ptr_q  <= '0;
      left_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      max_q      <= max_d;
      copies_q   <= copies_d;
      scan_ptr_q <= scan_ptr_d;
      left_q     <= left_d;
      rd_vld_q   <= rd_vld_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      status_q <= res_status;
      data_q   <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= DEPTH_EXT)
    else $error("entry count beyond store depth");

  a_copies_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copies_q <= count_q)
    else $error("max copy count exceeds entry count");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (copies_q == '0) && (max_q == MAX_FLOOR))
    else $error("empty queue keeps a maximum");

  a_deq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deq_finish |-> $past(cmd_i.accept && stat_o.deq_start))
    else $error("dequeue finish without a started dequeue");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |-> stat_o.out_free)
    else $error("result loaded over a waiting word");

endmodule

>>> hdl/max_tracking_fifo.sv
// top level of the max tracking fifo
//
//   channel  signals                              dir  moves
//   in       in_valid_i in_ready_o command_i ...  in   one command word
//   out      out_valid_o out_ready_i status_o ... out  one result word
//   cfg      cfg_we_i cfg_wdata_i                 in   capacity register
//
// enqueue, query, unused commands and errors load their result word straight from the idle state
// a dequeue passes through S_DEQ: the head word comes out of the store's read register
// a dequeue that removes the last copy of the maximum adds a rescan (S_SCAN) over
// the n entries left, one store read per cycle
// reset is immediate, the store needs no clearing pass
// a result waiting on out_ready_i holds off the next word until it is taken
`timescale 1ns / 1ps

module max_tracking_fifo import mtf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               command_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  mtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  mtf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat)
  );

endmodule

>>> test/max_queue_checker.sv
// scoreboard for the max tracking fifo: models the queue and checks every result word
`timescale 1ns / 1ps

module max_queue_checker import mtf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               status_i,
  input  logic signed [DATA_W-1:0] data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
  } queue_result_t;

  // modeled queue contents and tracking state
  logic signed [DATA_W-1:0] entries [QUEUE_DEPTH];
  int unsigned              head;
  int unsigned              tail;
  int unsigned              fill;
  logic signed [DATA_W-1:0] peak;
  int unsigned              peak_copies;
  logic [CAP_W-1:0]         capacity;

  queue_result_t results_due [$];
  int            mismatches;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
  endfunction

  function automatic void note_value(logic signed [DATA_W-1:0] v);
    if (v > peak) begin
      peak = v;
      peak_copies = 1;
    end else if (v == peak) begin
      peak_copies++;
    end
  endfunction

  // walk the occupied entries from the head to find the new maximum
  function automatic void rescan_peak();
    int unsigned i;
    i = head;
    peak = MAX_FLOOR;
    peak_copies = 0;
    for (int unsigned n = 0; n < fill; n++) begin
      note_value(entries[i]);
      i = ring_next(i);
    end
  endfunction

  function automatic queue_result_t apply_command(logic [1:0] cmd,
                                                  logic signed [DATA_W-1:0] val);
    queue_result_t            r;
    int unsigned              limit;
    logic signed [DATA_W-1:0] v;
    r.status = ST_OK;
    r.data   = '0;
    limit = (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity;
    if (cmd == CMD_ENQ) begin
      if (fill >= limit) begin
        r.status = ST_FULL;
      end else begin
        v = (val == MOST_NEG) ? MAX_FLOOR : val;
        entries[tail] = v;
        tail = ring_next(tail);
        fill++;
        note_value(v);
      end
    end else if (cmd == CMD_DEQ) begin
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data = entries[head];
        head = ring_next(head);
        fill--;
        if (r.data == peak && peak_copies > 0) peak_copies--;
        if (peak_copies == 0) rescan_peak();
      end
    end else if (cmd == CMD_MAX) begin
      if (fill == 0) r.status = ST_EMPTY;
      else r.data = peak;
    end
    return r;
  endfunction

  function automatic void report_mismatch(string what, logic signed [DATA_W-1:0] want_v,
                                          logic signed [DATA_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      head = 0;
      tail = 0;
      fill = 0;
      peak = MAX_FLOOR;
      peak_copies = 0;
      capacity = CAP_RESET;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      // retire before accepting, a word's result never leaves on its own edge
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing pending, status %0d data %0d",
                   $time, status_i, data_i);
        end else begin
          want = results_due.pop_front();
          if (status_i !== want.status) report_mismatch("status", want.status, status_i);
          if (data_i !== want.data) report_mismatch("data", want.data, data_i);
        end
      end
      if (in_valid_i && in_ready_i) results_due.push_back(apply_command(command_i, value_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= results_due.size();
  end

endmodule

>>> test/tb_top.sv
// stimulus and verdict for the max tracking fifo, results are checked by max_queue_checker
`timescale 1ns / 1ps

module tb_top;
  import mtf_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned LONG_HOLD   = 120;
  localparam logic [1:0]  CMD_NONE    = 2'd3;
  localparam logic signed [DATA_W-1:0] TOP_VALUE = 32'sh7fff_ffff;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [1:0]               command   = CMD_ENQ;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;

  int          fail_count;
  int          pending;
  bit          calm            = 1'b0;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_taken = 1'b0;
  int          stall_left      = 0;
  int          stall_pct       = 10;
  int          gap_pct         = 25;
  int unsigned cycles          = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  max_tracking_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .data_o      (data)
  );

  max_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .command_i    (command),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .data_i       (data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("max_tracking_fifo test failed");
      $finish;
    end
  end

  // receiver: short random stalls, plus one long hold so the block backs up
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      stall_left      <= LONG_HOLD - 1;
      out_ready       <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic signed [DATA_W-1:0] val);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every result is back and the block takes words again
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(int narrow_pct);
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return TOP_VALUE;
        1:       return MAX_FLOOR;
        2:       return MOST_NEG;
        default: return '0;
      endcase
    end else if (r < 8 + narrow_pct) begin
      // narrow range makes repeated maxima likely
      k = $urandom_range(0, 16);
      return k - 8;
    end
    return $urandom();
  endfunction

  // fill and drain in tides of random length so the queue level wanders
  task automatic run_mixed(int count, int narrow_pct);
    int         tide;
    int         enq_pct;
    int         r;
    logic [1:0] cmd;
    tide = 0;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (tide == 0) begin
        tide      = $urandom_range(6, 24);
        enq_pct   = $urandom_range(0, 1) ? 70 : 30;
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
        stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : 12;
      end
      tide--;
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_NONE;
      else if (r < 3 + enq_pct) cmd = CMD_ENQ;
      else if (r < 3 + enq_pct + (97 - enq_pct) * 2 / 3) cmd = CMD_DEQ;
      else cmd = CMD_MAX;
      send_word(cmd, pick_value(narrow_pct));
    end
  endtask

  task automatic run_fill(int enq_target);
    int sent;
    int r;
    sent = 0;
    gap_pct = 20;
    while (sent < enq_target) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_word(CMD_NONE, $urandom());
      end else if (r < 8) begin
        send_word(CMD_MAX, $urandom());
      end else begin
        send_word(CMD_ENQ, pick_value(50));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue and the unused command
    send_word(CMD_DEQ, '0);
    send_word(CMD_MAX, '0);
    send_word(CMD_NONE, -32'sd1);
    // max leaves and a rescan finds the next one, then duplicates of the max
    send_word(CMD_ENQ, 32'sd7);
    send_word(CMD_ENQ, 32'sd2);
    send_word(CMD_ENQ, 32'sd6);
    send_word(CMD_MAX, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_MAX, '0);
    send_word(CMD_ENQ, 32'sd6);
    send_word(CMD_DEQ, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_MAX, '0);
    // value extremes, the most negative one saturates
    send_word(CMD_ENQ, MOST_NEG);
    send_word(CMD_ENQ, TOP_VALUE);
    send_word(CMD_ENQ, MAX_FLOOR);
    send_word(CMD_MAX, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_DEQ, '0);
    // capacity dropped below the fill level
    write_capacity(11'd3);
    send_word(CMD_ENQ, -32'sd5);
    send_word(CMD_ENQ, -32'sd9);
    send_word(CMD_ENQ, -32'sd5);
    write_capacity(11'd1);
    send_word(CMD_ENQ, 32'sd4);
    send_word(CMD_DEQ, '0);
    send_word(CMD_ENQ, 32'sd4);
    send_word(CMD_DEQ, '0);
    send_word(CMD_DEQ, '0);
    send_word(CMD_ENQ, 32'sd4);

    write_capacity(11'd2047);
    long_hold_req <= 1'b1;
    run_mixed(80, 30);
    write_capacity(11'd3);
    run_mixed(50, 70);
    write_capacity(11'd1);
    run_mixed(30, 50);
    write_capacity(11'd0);
    run_mixed(15, 50);
    write_capacity(CAP_W'($urandom_range(2, 40)));
    run_mixed(50, 40);
    write_capacity(11'd1024);
    run_fill(QUEUE_DEPTH + 6);

    // last part with no idling on either side, queue stays far above capacity
    calm <= 1'b1;
    write_capacity(CAP_W'($urandom_range(1, 16)));
    run_mixed(50, 40);

    settle();
    repeat (QUEUE_DEPTH + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("max_tracking_fifo test passed");
    end else begin
      $display("max_tracking_fifo test failed");
    end
    $finish;
  end

endmodule
